// ===== src/pid_motor_position_controller_assert.svh =====
// Assertion helpers for the motor position PID controller.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef PID_MOTOR_POSITION_CONTROLLER_ASSERT_SVH
`define PID_MOTOR_POSITION_CONTROLLER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMPC_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/pmpc_pkg.sv =====
package pmpc_pkg;

	localparam int POS_W     = 16;
	localparam int SUM_W     = 32;
	localparam int GAIN_W    = 24;
	localparam int FRAC_W    = 16;
	localparam int DUTY_W    = 8;
	localparam int DIR_W     = 2;
	localparam int CFG_IDX_W = 2;

	localparam int ERR_W  = POS_W + 1;
	localparam int DIFF_W = ERR_W + 1;

	// Products of a gain (zero-extended to signed) and a signed operand.
	localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
	localparam int PROD_I_W = GAIN_W + 1 + SUM_W;
	localparam int PROD_D_W = GAIN_W + 1 + DIFF_W;
	localparam int PROD_MAX_A = (PROD_P_W > PROD_D_W) ? PROD_P_W : PROD_D_W;
	localparam int PROD_MAX   = (PROD_MAX_A > PROD_I_W) ? PROD_MAX_A : PROD_I_W;
	localparam int TOT_W      = PROD_MAX + 2;

	// Limit on the integral product beyond which the duty is forced to full scale.
	localparam int BIG_SHIFT = 60;
	localparam int LIM_W     = (TOT_W > BIG_SHIFT + 2) ? TOT_W : BIG_SHIFT + 2;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [ERR_W-1:0]  err_t;
	typedef logic signed [DIFF_W-1:0] diff_t;
	typedef logic [GAIN_W-1:0]        gain_t;
	typedef logic [DUTY_W-1:0]        duty_t;
	typedef logic [DIR_W-1:0]         dir_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;
	typedef logic signed [PROD_P_W-1:0] prod_p_t;
	typedef logic signed [PROD_I_W-1:0] prod_i_t;
	typedef logic signed [PROD_D_W-1:0] prod_d_t;

	localparam logic OP_EDGE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam dir_t DIR_NONE = dir_t'(0);
	localparam dir_t DIR_CW   = dir_t'(1);
	localparam dir_t DIR_CCW  = dir_t'(2);

	localparam cfg_idx_t CFG_PROP  = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_INTEG = cfg_idx_t'(1);
	localparam cfg_idx_t CFG_DERIV = cfg_idx_t'(2);

	localparam gain_t PROP_RST  = gain_t'(196608);
	localparam gain_t INTEG_RST = gain_t'(655);
	localparam gain_t DERIV_RST = gain_t'(131);

	localparam pos_t  POS_RST  = pos_t'(30);
	localparam pos_t  TGT_RST  = pos_t'(50);
	localparam pos_t  POS_ONE  = pos_t'(1);
	localparam duty_t DUTY_RST = duty_t'(150);
	localparam duty_t DUTY_MAX = duty_t'(255);

	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	localparam logic [LIM_W-1:0] BIG_LIMIT = LIM_W'(1) << BIG_SHIFT;

endpackage

// ===== src/pmpc_cmd_if.sv =====
interface pmpc_cmd_if;
	import pmpc_pkg::*;

	logic valid;
	logic ready;
	logic operation;
	logic phase_b;
	logic button_up;
	logic button_down;

	modport source (output valid, output operation, output phase_b, output button_up,
		output button_down, input ready);
	modport sink (input valid, input operation, input phase_b, input button_up,
		input button_down, output ready);
endinterface

// ===== src/pmpc_status_if.sv =====
interface pmpc_status_if;
	import pmpc_pkg::*;

	logic  valid;
	logic  ready;
	duty_t pwm_duty;
	dir_t  direction;
	pos_t  position;
	pos_t  target;

	modport source (output valid, output pwm_duty, output direction, output position,
		output target, input ready);
	modport sink (input valid, input pwm_duty, input direction, input position,
		input target, output ready);
endinterface

// ===== src/pmpc_cfg_if.sv =====
interface pmpc_cfg_if;
	import pmpc_pkg::*;

	logic     valid;
	logic     ready;
	cfg_idx_t index;
	gain_t    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/pid_motor_position_controller.sv =====
// A result item passes through the stage 1, stage 2 and stage 3 registers after its command
// item is accepted, and the stage 3 register drives status.
// Throughput: one item per cycle while status is ready; the three-stage pipeline (state update,
// gain multiplies, sum and saturate) keeps one item per stage; ready falls only when all are full.
// Reset (arst_n low, asynchronous): position 30, target 50, error sum and previous error 0,
// duty 150, direction not set, gains 3.0, about 0.01 and about 0.002 in Q8.16.
`include "pid_motor_position_controller_assert.svh"

module pid_motor_position_controller (
	input logic          clk,
	input logic          arst_n,
	pmpc_cmd_if.sink     cmd,
	pmpc_status_if.source status,
	pmpc_cfg_if.sink     cfg
);
	import pmpc_pkg::*;

	// Gain registers, written through the configuration channel.
	gain_t prop_q;
	gain_t integ_q;
	gain_t deriv_q;

	// Controller state. It is updated in the cycle an item is accepted so that the next
	// item, which may arrive in the following cycle, already sees it.
	pos_t pos_q;
	pos_t tgt_q;
	sum_t sum_q;
	err_t prev_q;
	dir_t dir_q;

	// Pipeline stage valid bits and per-stage ready.
	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic rdy1;
	logic rdy2;
	logic rdy3;
	logic acc;

	// Stage 1 payload: the PID operands and the visible state after this item.
	logic  run_s1;
	err_t  err_s1;
	sum_t  sum_s1;
	diff_t diff_s1;
	pos_t  pos_s1;
	pos_t  tgt_s1;
	dir_t  dir_s1;

	// Stage 2 payload: the three gain products.
	logic    run_s2;
	prod_p_t prod_p_s2;
	prod_i_t prod_i_s2;
	prod_d_t prod_d_s2;
	pos_t    pos_s2;
	pos_t    tgt_s2;
	dir_t    dir_s2;

	// Stage 3 is the result register. The duty register also holds the duty state: it
	// keeps its value whenever an item does not run the PID update.
	duty_t duty_s3;
	dir_t  dir_s3;
	pos_t  pos_s3;
	pos_t  tgt_s3;

	// Combinational next-state values.
	logic                 is_tick;
	logic                 run_c;
	err_t                 err_c;
	logic signed [SUM_W:0] sum_wide;
	sum_t                 sum_c;
	diff_t                diff_c;
	pos_t                 pos_next;
	pos_t                 tgt_next;
	dir_t                 dir_next;

	// Multiply operands and results.
	logic signed [GAIN_W:0] prop_sx;
	logic signed [GAIN_W:0] integ_sx;
	logic signed [GAIN_W:0] deriv_sx;
	prod_p_t prod_p_c;
	prod_i_t prod_i_c;
	prod_d_t prod_d_c;

	// Final sum, magnitude and saturation.
	logic signed [TOT_W-1:0] total_c;
	logic [TOT_W-1:0]        mag_c;
	logic [PROD_I_W-1:0]     mag_i_c;
	logic                    big_c;
	duty_t                   duty_c;

	// Configuration writes are always taken; an index past the last gain is dropped.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_q  <= PROP_RST;
			integ_q <= INTEG_RST;
			deriv_q <= DERIV_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PROP:  prop_q  <= cfg.data;
				CFG_INTEG: integ_q <= cfg.data;
				CFG_DERIV: deriv_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Each stage can take a new item when it is empty or its content moves on. A bubble
	// anywhere in the pipe therefore lets the input side keep going while a result waits.
	assign rdy3      = !valid_s3 || status.ready;
	assign rdy2      = !valid_s2 || rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign cmd.ready = rdy1;
	assign acc       = cmd.valid && rdy1;

	// State update for the accepted item. The error is exact at one bit more than the
	// position, the sum saturates at its signed limits, and the direction uses the target
	// before the buttons move it.
	always_comb begin
		is_tick  = (cmd.operation == OP_TICK);
		run_c    = is_tick && (pos_q != tgt_q);
		err_c    = ERR_W'(tgt_q) - ERR_W'(pos_q);
		sum_wide = (SUM_W+1)'(sum_q) + (SUM_W+1)'(err_c);
		if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
			sum_c = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
		end else begin
			sum_c = sum_wide[SUM_W-1:0];
		end
		diff_c = DIFF_W'(err_c) - DIFF_W'(prev_q);

		pos_next = pos_q;
		tgt_next = tgt_q;
		dir_next = dir_q;
		if (!is_tick) begin
			pos_next = cmd.phase_b ? pos_q - POS_ONE : pos_q + POS_ONE;
		end else begin
			if (pos_q < tgt_q) begin
				dir_next = DIR_CW;
			end else if (pos_q > tgt_q) begin
				dir_next = DIR_CCW;
			end
			if (cmd.button_up) begin
				tgt_next = tgt_q + POS_ONE;
			end else if (cmd.button_down) begin
				tgt_next = tgt_q - POS_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_RST;
			tgt_q  <= TGT_RST;
			sum_q  <= '0;
			prev_q <= '0;
			dir_q  <= DIR_NONE;
		end else if (acc) begin
			pos_q <= pos_next;
			tgt_q <= tgt_next;
			dir_q <= dir_next;
			if (run_c) begin
				sum_q  <= sum_c;
				prev_q <= err_c;
			end
		end
	end

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy1) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			run_s1  <= run_c;
			err_s1  <= err_c;
			sum_s1  <= sum_c;
			diff_s1 <= diff_c;
			pos_s1  <= pos_next;
			tgt_s1  <= tgt_next;
			dir_s1  <= dir_next;
		end
	end

	// Stage 2: the three gain products, each a single multiplier. Gains are unsigned, so
	// they get a zero sign bit before the signed multiply.
	always_comb begin
		prop_sx  = $signed({1'b0, prop_q});
		integ_sx = $signed({1'b0, integ_q});
		deriv_sx = $signed({1'b0, deriv_q});
		prod_p_c = PROD_P_W'(prop_sx) * PROD_P_W'(err_s1);
		prod_i_c = PROD_I_W'(integ_sx) * PROD_I_W'(sum_s1);
		prod_d_c = PROD_D_W'(deriv_sx) * PROD_D_W'(diff_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && rdy2) begin
			run_s2    <= run_s1;
			prod_p_s2 <= prod_p_c;
			prod_i_s2 <= prod_i_c;
			prod_d_s2 <= prod_d_c;
			pos_s2    <= pos_s1;
			tgt_s2    <= tgt_s1;
			dir_s2    <= dir_s1;
		end
	end

	// Stage 3: sum the products, drop the sixteen fraction bits of the magnitude (the same
	// as truncating toward zero first) and saturate to the duty range. An integral product
	// past the big limit forces full scale on its own.
	always_comb begin
		total_c = TOT_W'(prod_p_s2) + TOT_W'(prod_i_s2) + TOT_W'(prod_d_s2);
		mag_c   = total_c[TOT_W-1] ? TOT_W'(-total_c) : TOT_W'(total_c);
		mag_i_c = prod_i_s2[PROD_I_W-1] ? PROD_I_W'(-prod_i_s2) : PROD_I_W'(prod_i_s2);
		big_c   = LIM_W'(mag_i_c) > BIG_LIMIT;
		if (big_c || (|mag_c[TOT_W-1:FRAC_W+DUTY_W])) begin
			duty_c = DUTY_MAX;
		end else begin
			duty_c = mag_c[FRAC_W+DUTY_W-1:FRAC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			duty_s3  <= DUTY_RST;
		end else if (rdy3) begin
			valid_s3 <= valid_s2;
			if (valid_s2 && run_s2) begin
				duty_s3 <= duty_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && rdy3) begin
			dir_s3 <= dir_s2;
			pos_s3 <= pos_s2;
			tgt_s3 <= tgt_s2;
		end
	end

	assign status.valid     = valid_s3;
	assign status.pwm_duty  = duty_s3;
	assign status.direction = dir_s3;
	assign status.position  = pos_s3;
	assign status.target    = tgt_s3;

	// The input side only stalls when every stage holds an item.
	`PMPC_ASSERT_SAME(a_stall_only_full, !cmd.ready, valid_s1 && valid_s2 && valid_s3, "input stalled with a free stage")
	// An encoder edge never touches the target or the PID memory.
	`PMPC_ASSERT_NEXT(a_edge_keeps_pid, acc && cmd.operation == OP_EDGE, $stable(sum_q) && $stable(prev_q) && $stable(tgt_q), "edge item changed PID state")
	// A tick at the target keeps the error memory and the direction.
	`PMPC_ASSERT_NEXT(a_hold_at_target, acc && cmd.operation == OP_TICK && pos_q == tgt_q, $stable(sum_q) && $stable(prev_q) && $stable(dir_q), "tick at target changed PID state")
	// An item that runs the update always carries a nonzero error.
	`PMPC_ASSERT_SAME(a_run_has_error, valid_s1 && run_s1, err_s1 != '0, "PID update with zero error")

endmodule

// ===== verif/pid_motor_position_controller_tb.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the motor position PID controller.
//
// A driver pulls command items from a plan queue and offers them on the command
// channel; every accepted item is run through a cycle-free model of the controller
// kept in this module, and the status item it must produce is queued. A monitor
// compares each status item that leaves the block with the oldest queued one.
// The gains are rewritten between phases while the block is empty, and the phases
// cycle through four mixes of sender gaps and receiver stalls.
module pid_motor_position_controller_tb;
	import pmpc_pkg::*;

	// One command item as the plan queue holds it.
	typedef struct packed {
		logic op;
		logic pb;
		logic up;
		logic dn;
	} motor_cmd_t;

	// One status item: what the block reports after each command.
	typedef struct packed {
		duty_t duty;
		dir_t  dir;
		pos_t  pos;
		pos_t  tgt;
	} motor_status_t;

	// Handshake pacing modes used by the phases.
	typedef enum int {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_SINK_STALLS,
		PACE_BOTH
	} pace_e;

	// The register index past the last gain; writes to it must change nothing.
	localparam cfg_idx_t CFG_SPARE = cfg_idx_t'(3);

	localparam int          GAP_PCT       = 74;
	localparam int          BOTH_PCT      = 14;
	localparam int          SETTLE_CYCLES = 10;
	localparam int          QUIET_LIMIT   = 5000;
	localparam int          PRESS_CYCLES  = 400;
	localparam int          PHASE_ITEMS   = 230;
	localparam int          PRINT_CAP     = 40;
	localparam int unsigned GAIN_TOP      = (1 << GAIN_W) - 1;
	localparam int unsigned SMALL_TOP     = 1 << (FRAC_W + 2);

	logic clk;
	logic arst_n;

	pmpc_cmd_if    cmd_ch();
	pmpc_status_if status_ch();
	pmpc_cfg_if    cfg_ch();

	pid_motor_position_controller u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.status (status_ch),
		.cfg    (cfg_ch)
	);

	// Plan of command items still to be offered, and status items still owed.
	motor_cmd_t    cmd_plan[$];
	motor_status_t status_owed[$];

	// Controller model state. It starts at the block's reset values, which is
	// sound because reset is applied exactly once, at time zero.
	gain_t  gain_p   = PROP_RST;
	gain_t  gain_i   = INTEG_RST;
	gain_t  gain_d   = DERIV_RST;
	pos_t   pos_cnt  = POS_RST;
	pos_t   setpoint = TGT_RST;
	longint err_acc  = 0;
	longint last_err = 0;
	duty_t  duty_now = DUTY_RST;
	dir_t   dir_now  = DIR_NONE;

	// Planning view of the count and the setpoint. These do not depend on the
	// gains, so the stimulus can steer the count toward the setpoint.
	pos_t   plan_pos = POS_RST;
	pos_t   plan_tgt = TGT_RST;

	// Pacing knobs and the long receiver hold-off used for back-pressure.
	int send_gap_pct   = 0;
	int sink_stall_pct = 0;
	int stall_hold     = 0;

	logic       cmd_taken      = 1'b0;
	motor_cmd_t next_cmd;
	int         mismatch_count = 0;
	int         results_seen   = 0;
	int         quiet_cycles   = 0;

	// Advance the controller by one command item and return the status item it
	// causes. An encoder edge only moves the count. A tick runs the PID update
	// when the count is off the setpoint, then picks the drive direction from the
	// count and setpoint as they stood, and only then applies the buttons.
	function automatic motor_status_t advance_controller(logic op, logic pb, logic up,
		logic dn);
		motor_status_t    res;
		longint           e;
		longint           d;
		longint           total;
		longint           gp;
		longint           gi;
		longint           gd;
		longint unsigned  mag;
		longint unsigned  lim;

		if (op == OP_EDGE) begin
			pos_cnt = pb ? pos_cnt - POS_ONE : pos_cnt + POS_ONE;
		end else begin
			if (pos_cnt != setpoint) begin
				// The operands widen to 64 bits before the subtraction, so the
				// error is exact and never wraps.
				e = longint'(setpoint) - longint'(pos_cnt);
				err_acc = err_acc + e;
				if (err_acc > SUM_MAX) err_acc = longint'(SUM_MAX);
				if (err_acc < SUM_MIN) err_acc = longint'(SUM_MIN);
				d = e - last_err;
				last_err = e;
				gp = longint'(gain_p);
				gi = longint'(gain_i);
				gd = longint'(gain_d);
				lim = 64'(BIG_LIMIT);
				mag = (err_acc < 0) ? -err_acc : err_acc;
				if (gi != 0 && mag > lim / gi) begin
					// An integral term this large pins the duty at full scale.
					duty_now = DUTY_MAX;
				end else begin
					total = gp * e + gi * err_acc + gd * d;
					mag = (total < 0) ? -total : total;
					mag = mag >> FRAC_W;
					duty_now = (mag > DUTY_MAX) ? DUTY_MAX : duty_t'(mag);
				end
			end
			if (pos_cnt < setpoint) dir_now = DIR_CW;
			else if (pos_cnt > setpoint) dir_now = DIR_CCW;
			if (up) setpoint = setpoint + POS_ONE;
			else if (dn) setpoint = setpoint - POS_ONE;
		end
		res.duty = duty_now;
		res.dir  = dir_now;
		res.pos  = pos_cnt;
		res.tgt  = setpoint;
		return res;
	endfunction

	// Append one command item to the plan and follow its effect on the count
	// and the setpoint.
	function automatic void push_item(logic op, logic pb, logic up, logic dn);
		motor_cmd_t c;

		c.op = op;
		c.pb = pb;
		c.up = up;
		c.dn = dn;
		cmd_plan.push_back(c);
		if (op == OP_EDGE) begin
			plan_pos = pb ? plan_pos - POS_ONE : plan_pos + POS_ONE;
		end else begin
			if (up) plan_tgt = plan_tgt + POS_ONE;
			else if (dn) plan_tgt = plan_tgt - POS_ONE;
		end
	endfunction

	// Random motion shaped like a closed loop: most edges move the count toward
	// the setpoint, ticks come every few edges with random buttons, and now and
	// then a run of edges in one direction opens up a large error. Buttons and
	// the phase level are randomized on the items that ignore them as well.
	task automatic queue_motion(int n);
		int   left;
		int   burst;
		int   r;
		logic pb;

		left = n;
		while (left > 0) begin
			r = $urandom_range(99);
			if (r < 3) begin
				burst = $urandom_range(150, 20);
				if (burst > left) burst = left;
				pb = 1'($urandom_range(1, 0));
				repeat (burst) push_item(OP_EDGE, pb, 1'($urandom_range(1, 0)),
					1'($urandom_range(1, 0)));
				left = left - burst;
			end else if (r < 38) begin
				push_item(OP_TICK, 1'($urandom_range(1, 0)), $urandom_range(99) < 30,
					$urandom_range(99) < 30);
				left = left - 1;
			end else begin
				if (plan_pos == plan_tgt || $urandom_range(99) < 20)
					pb = 1'($urandom_range(1, 0));
				else pb = (plan_pos > plan_tgt);
				push_item(OP_EDGE, pb, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
				left = left - 1;
			end
		end
	endtask

	task automatic report_mismatch(string what);
		if (mismatch_count < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
		mismatch_count = mismatch_count + 1;
	endtask

	// Change the pacing at a rising edge so the driver and receiver, which act on
	// the falling edge, never see a half-made change.
	task automatic set_pace(pace_e mode);
		@(posedge clk);
		send_gap_pct = (mode == PACE_SEND_GAPS) ? GAP_PCT : (mode == PACE_BOTH) ? BOTH_PCT : 0;
		sink_stall_pct = (mode == PACE_SINK_STALLS) ? GAP_PCT :
			(mode == PACE_BOTH) ? BOTH_PCT : 0;
	endtask

	// Wait until every planned item has been taken and every status item owed
	// has come back, then let the pipeline run on so that it can show anything
	// it should not produce.
	task automatic wait_for_quiet();
		do begin
			@(posedge clk);
			#1;
		end while (cmd_plan.size() != 0 || cmd_ch.valid || status_owed.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write on the configuration channel. The model's copy of the
	// gain changes at the edge where the write is taken.
	task automatic write_reg(cfg_idx_t idx, gain_t val);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = val;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		case (idx)
			CFG_PROP: begin
				gain_p = val;
			end
			CFG_INTEG: begin
				gain_i = val;
			end
			CFG_DERIV: begin
				gain_d = val;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic write_gains(gain_t kp, gain_t ki, gain_t kd);
		write_reg(CFG_PROP, kp);
		write_reg(CFG_INTEG, ki);
		write_reg(CFG_DERIV, kd);
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Command driver. A new item goes out on the falling edge once the previous
	// one has been taken; while the sender is idle the valid stays low. An offered
	// item is never withdrawn before the block takes it.
	always @(negedge clk) begin
		if (!cmd_ch.valid || cmd_taken) begin
			if (cmd_plan.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				next_cmd = cmd_plan.pop_front();
				cmd_ch.valid       <= 1'b1;
				cmd_ch.operation   <= next_cmd.op;
				cmd_ch.phase_b     <= next_cmd.pb;
				cmd_ch.button_up   <= next_cmd.up;
				cmd_ch.button_down <= next_cmd.dn;
			end else begin
				cmd_ch.valid <= 1'b0;
			end
		end
	end

	// Status receiver. A long hold-off, when one is requested, is counted down
	// here cycle by cycle; otherwise ready stalls at random per the pacing.
	always @(negedge clk) begin
		if (stall_hold != 0) begin
			status_ch.ready <= 1'b0;
			stall_hold <= stall_hold - 1;
		end else begin
			status_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Monitor. On each rising edge an accepted command item is run through the
	// model, and an accepted status item is checked field by field against the
	// oldest status item owed.
	always @(posedge clk) begin
		motor_status_t want;

		cmd_taken <= cmd_ch.valid && cmd_ch.ready;
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				status_owed.push_back(advance_controller(cmd_ch.operation, cmd_ch.phase_b,
					cmd_ch.button_up, cmd_ch.button_down));
			end
			if (status_ch.valid && status_ch.ready) begin
				results_seen = results_seen + 1;
				if (status_owed.size() == 0) begin
					report_mismatch($sformatf("status item %0d arrived with none owed",
						results_seen));
				end else begin
					want = status_owed.pop_front();
					if (status_ch.pwm_duty !== want.duty)
						report_mismatch($sformatf("item %0d pwm_duty %0d, expected %0d",
							results_seen, status_ch.pwm_duty, want.duty));
					if (status_ch.direction !== want.dir)
						report_mismatch($sformatf("item %0d direction %0d, expected %0d",
							results_seen, status_ch.direction, want.dir));
					if (status_ch.position !== want.pos)
						report_mismatch($sformatf("item %0d position %0d, expected %0d",
							results_seen, status_ch.position, want.pos));
					if (status_ch.target !== want.tgt)
						report_mismatch($sformatf("item %0d target %0d, expected %0d",
							results_seen, status_ch.target, want.tgt));
				end
			end
		end
	end

	// Watchdog: a long run of cycles in which no channel moves an item means the
	// block has hung or dropped a status item.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (status_ch.valid && status_ch.ready) ||
			(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("pid_motor_position_controller_tb NOT OK");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int    ph;
		int    step;
		gain_t kp;
		gain_t ki;
		gain_t kd;

		cmd_ch.valid       = 1'b0;
		cmd_ch.operation   = OP_EDGE;
		cmd_ch.phase_b     = 1'b0;
		cmd_ch.button_up   = 1'b0;
		cmd_ch.button_down = 1'b0;
		status_ch.ready    = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_PROP;
		cfg_ch.data        = '0;
		arst_n             = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed opening with the reset gains and no idling. The first items are
		// edges, so the direction is still unset in their status; the buttons on
		// them must have no effect.
		set_pace(PACE_FULL);
		push_item(OP_EDGE, 1'b0, 1'b1, 1'b1);
		push_item(OP_EDGE, 1'b1, 1'b1, 1'b0);
		push_item(OP_EDGE, 1'b0, 1'b0, 1'b1);
		push_item(OP_TICK, 1'b0, 1'b0, 1'b0);
		// With both buttons pressed only the up button counts.
		push_item(OP_TICK, 1'b1, 1'b1, 1'b1);
		push_item(OP_TICK, 1'b0, 1'b0, 1'b1);
		// Close the gap from both sides, count rising and setpoint falling, until
		// the two meet. A tick at that point must leave duty, direction and the
		// error history untouched.
		step = 0;
		while (plan_pos != plan_tgt) begin
			if (step[0]) push_item(OP_TICK, 1'b0, 1'b0, 1'b1);
			else push_item(OP_EDGE, 1'b0, 1'b0, 1'b0);
			step = step + 1;
		end
		push_item(OP_TICK, 1'b0, 1'b0, 1'b0);
		push_item(OP_TICK, 1'b0, 1'b1, 1'b1);
		push_item(OP_TICK, 1'b0, 1'b0, 1'b0);
		wait_for_quiet();

		// The spare index must be ignored; later ticks would show a changed gain.
		write_reg(CFG_SPARE, gain_t'($urandom()));

		// Random phases. Each one loads a gain setting, including all zeros, all
		// ones and mixes of full-scale and small gains, and uses one of four pacings.
		for (ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin
					kp = PROP_RST;
					ki = INTEG_RST;
					kd = DERIV_RST;
				end
				1: begin
					kp = '0;
					ki = '0;
					kd = '0;
				end
				2: begin
					kp = '1;
					ki = '1;
					kd = '1;
				end
				3: begin
					kp = gain_t'($urandom_range(GAIN_TOP, 0));
					ki = gain_t'($urandom_range(GAIN_TOP, 0));
					kd = gain_t'($urandom_range(GAIN_TOP, 0));
				end
				5: begin
					kp = '1;
					ki = '0;
					kd = gain_t'($urandom_range(GAIN_TOP, 0));
				end
				7: begin
					kp = gain_t'($urandom_range(SMALL_TOP, 0));
					ki = gain_t'($urandom_range(SMALL_TOP, 0));
					kd = '1;
				end
				default: begin
					kp = gain_t'($urandom_range(SMALL_TOP, 0));
					ki = gain_t'($urandom_range(SMALL_TOP, 0));
					kd = gain_t'($urandom_range(SMALL_TOP, 0));
				end
			endcase
			write_gains(kp, ki, kd);
			set_pace(pace_e'(ph % 4));
			// In the first phase the receiver holds off for a long stretch while
			// the sender keeps offering, so the pipeline fills and ready drops.
			if (ph == 0) stall_hold = PRESS_CYCLES;
			queue_motion(PHASE_ITEMS);
			wait_for_quiet();
		end

		if (mismatch_count == 0) begin
			$display("pid_motor_position_controller_tb OK");
		end else begin
			$display("pid_motor_position_controller_tb NOT OK");
		end
		$finish;
	end

endmodule
